// File: rtl/apj_pkg.sv
package apj_pkg;

    // Angle format on the ports
    localparam int ANGLE_W   = 32;
    localparam int FRAC_BITS = 28;

    // Internal fixed-point values, wide enough for every monomial and term
    localparam int VAL_W  = 52;
    localparam int HALF_W = VAL_W / 2;
    localparam int ACC_W  = VAL_W + 5;

    // Polynomial shape
    localparam int HIP_DEG      = 6;
    localparam int ANKLE_DEG    = 4;
    localparam int TERM_N       = 28;
    localparam int ANKLE_TERM_N = 15;

    // Pipeline timing
    localparam int MUL_LAT = 4;
    localparam int LVL_N   = 5;
    localparam int SUM_LAT = 4;
    localparam int LAT     = 1 + LVL_N * MUL_LAT + MUL_LAT + SUM_LAT;

    typedef logic signed [VAL_W-1:0]   val_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    localparam val_t ONE_VAL = val_t'(64'd1 << FRAC_BITS);
    localparam acc_t ANGLE_MAX_ACC = acc_t'((64'sd1 <<< (ANGLE_W - 1)) - 64'sd1);
    localparam acc_t ANGLE_MIN_ACC = -ANGLE_MAX_ACC - acc_t'(1);

    localparam longint unsigned FIVE_POW8      = 64'd390625;
    localparam longint unsigned FIVE_POW8_HALF = 64'd195312;

    // Coefficients as integers over 10^8, in term order
    localparam int ROLL_N [TERM_N] = '{
        1343500, -4660200, -3370300, 3656500, 14746000, 2223800, 2770200,
        -22557000, -4930700, -5455400, -8261800, 23134000, 2098700, -8842400,
        -221610, 6931300, -15597000, 2284200, 8870100, 41012, 57241000,
        -1818900, 3645500, -1598800, 5429800, 142280, -57243000, 3703
    };

    localparam int PITCH_N [TERM_N] = '{
        14104000, -76434000, -2453000, 181410000, -5608600, -4464100,
        -244870000, 27126000, 26961000, 2156100, 181630000, -23275000,
        -42397000, -3361300, -3488100, -76579000, 19587000, 26225000,
        -6439600, -1690300, 51084000, 14082000, -7475900, -3985300, 3155700,
        -3574100, 51062000, -15647000
    };

    localparam int ANKLE_N [ANKLE_TERM_N] = '{
        -729070, 2916300, 906220, -4374500, -2718700, -1160800, 2916300,
        2718700, 2321700, -53853000, -729080, -906210, -1160900, 53853000,
        -130790
    };

    // Slot of monomial x^i*y^j: descending x power, then descending y power
    function automatic int mono_idx(int deg, int i, int j);
        int pos;
        pos = 0;
        for (int k = deg; k > i; k--)
            pos += deg - k + 1;
        return pos + deg - i - j;
    endfunction

    // Multiplier level that produces x^i*y^j (zero: available at entry)
    function automatic int mono_level(int i, int j);
        if (i + j <= 1)
            return 0;
        else if (j == 0)
            return i - 1;
        else if (i == 0)
            return j - 1;
        else
            return (i > j) ? i : j;
    endfunction

    // First operand slot of that product
    function automatic int mono_opa(int deg, int i, int j);
        if (i + j <= 1)
            return 0;
        else if (j == 0)
            return mono_idx(deg, i - 1, 0);
        else if (i == 0)
            return mono_idx(deg, 0, j - 1);
        else
            return mono_idx(deg, i, 0);
    endfunction

    // Second operand slot of that product
    function automatic int mono_opb(int deg, int i, int j);
        if (i + j <= 1)
            return 0;
        else if (j == 0)
            return mono_idx(deg, 1, 0);
        else if (i == 0)
            return mono_idx(deg, 0, 1);
        else
            return mono_idx(deg, 0, j);
    endfunction

    // round(|n| * 2^F / 10^8) with the sign of n
    function automatic val_t coef_fixed(int n);
        longint unsigned m;
        longint unsigned c;
        m = (n < 0) ? longint'(-n) : longint'(n);
        c = ((m << (FRAC_BITS - 8)) + FIVE_POW8_HALF) / FIVE_POW8;
        return (n < 0) ? -val_t'(c) : val_t'(c);
    endfunction

endpackage

// File: rtl/apj_motor_if.sv
interface apj_motor_if import apj_pkg::*; ();
    logic   valid;
    logic   ready;
    angle_t hip_yaw_motor;
    angle_t hip_left_motor;
    angle_t hip_right_motor;
    angle_t knee_front_motor;
    angle_t knee_back_motor;

    modport source
    (
        output valid, hip_yaw_motor, hip_left_motor, hip_right_motor,
               knee_front_motor, knee_back_motor,
        input  ready
    );

    modport sink
    (
        input  valid, hip_yaw_motor, hip_left_motor, hip_right_motor,
               knee_front_motor, knee_back_motor,
        output ready
    );
endinterface

// File: rtl/apj_joint_if.sv
interface apj_joint_if import apj_pkg::*; ();
    logic   valid;
    logic   ready;
    angle_t hip_yaw_joint;
    angle_t hip_roll_joint;
    angle_t hip_pitch_joint;
    angle_t knee_joint;
    angle_t ankle_joint;
    logic   saturated;

    modport source
    (
        output valid, hip_yaw_joint, hip_roll_joint, hip_pitch_joint,
               knee_joint, ankle_joint, saturated,
        input  ready
    );

    modport sink
    (
        input  valid, hip_yaw_joint, hip_roll_joint, hip_pitch_joint,
               knee_joint, ankle_joint, saturated,
        output ready
    );
endinterface

// File: rtl/apj_fxmul.sv
// Signed fixed-point multiply, rounded to nearest (ties away from zero).
// Four stages: magnitude, partial products, sum and round, sign.
module apj_fxmul import apj_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  val_t a,
    input  val_t b,
    output val_t p
);

    logic                   neg1_reg;
    logic                   neg2_reg;
    logic                   neg3_reg;
    logic [VAL_W-1:0]       ma_reg;
    logic [VAL_W-1:0]       mb_reg;
    logic [2*HALF_W-1:0]    pp00_reg;
    logic [2*HALF_W-1:0]    pp01_reg;
    logic [2*HALF_W-1:0]    pp10_reg;
    logic [2*HALF_W-1:0]    pp11_reg;
    logic [VAL_W-1:0]       mag_reg;
    val_t                   p_reg;
    logic [2*VAL_W-1:0]     full;

    // recombine partials and add the rounding half
    always_comb
    begin
        full = {pp11_reg, pp00_reg}
             + ((2*VAL_W)'(pp01_reg) << HALF_W)
             + ((2*VAL_W)'(pp10_reg) << HALF_W)
             + ((2*VAL_W)'(1) << (FRAC_BITS - 1));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= a[VAL_W-1] ^ b[VAL_W-1];
            ma_reg   <= a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
            mb_reg   <= b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);

            neg2_reg <= neg1_reg;
            pp00_reg <= (2*HALF_W)'(ma_reg[HALF_W-1:0])
                      * (2*HALF_W)'(mb_reg[HALF_W-1:0]);
            pp01_reg <= (2*HALF_W)'(ma_reg[HALF_W-1:0])
                      * (2*HALF_W)'(mb_reg[VAL_W-1:HALF_W]);
            pp10_reg <= (2*HALF_W)'(ma_reg[VAL_W-1:HALF_W])
                      * (2*HALF_W)'(mb_reg[HALF_W-1:0]);
            pp11_reg <= (2*HALF_W)'(ma_reg[VAL_W-1:HALF_W])
                      * (2*HALF_W)'(mb_reg[VAL_W-1:HALF_W]);

            neg3_reg <= neg2_reg;
            mag_reg  <= full[FRAC_BITS +: VAL_W];

            p_reg    <= neg3_reg ? -val_t'(mag_reg) : val_t'(mag_reg);
        end
    end

    assign p = p_reg;

endmodule

// File: rtl/apj_mono.sv
// Monomial generator: powers and cross products of the two variable pairs,
// one multiplier level after another; values that are done ride along.
// Group 0 is the hip pair (degree six), group 1 the ankle pair (degree four).
module apj_mono import apj_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  val_t hip_x,
    input  val_t hip_y,
    input  val_t ank_x,
    input  val_t ank_y,
    output val_t hip_mono [TERM_N],
    output val_t ank_mono [TERM_N]
);

    val_t bank [2][LVL_N+1][TERM_N];
    val_t var_x [2];
    val_t var_y [2];

    assign var_x[0] = hip_x;
    assign var_y[0] = hip_y;
    assign var_x[1] = ank_x;
    assign var_y[1] = ank_y;

    for (genvar g = 0; g < 2; g++)
    begin : g_grp
        localparam int DEG = (g == 0) ? HIP_DEG : ANKLE_DEG;
        localparam int CNT = (g == 0) ? TERM_N : ANKLE_TERM_N;

        for (genvar lv = 0; lv <= LVL_N; lv++)
        begin : g_lvl
            for (genvar i = 0; i <= HIP_DEG; i++)
            begin : g_i
                for (genvar j = 0; j <= HIP_DEG; j++)
                begin : g_j
                    if (i + j <= DEG)
                    begin : g_slot
                        localparam int S   = mono_idx(DEG, i, j);
                        localparam int MLV = mono_level(i, j);
                        localparam int OPA = mono_opa(DEG, i, j);
                        localparam int OPB = mono_opb(DEG, i, j);

                        if (lv == 0)
                        begin : g_init
                            // one, x and y enter directly
                            if (i == 0 && j == 0)
                            begin : g_one
                                assign bank[g][lv][S] = ONE_VAL;
                            end
                            else if (i == 1 && j == 0)
                            begin : g_x
                                assign bank[g][lv][S] = var_x[g];
                            end
                            else if (i == 0 && j == 1)
                            begin : g_y
                                assign bank[g][lv][S] = var_y[g];
                            end
                            else
                            begin : g_none
                                assign bank[g][lv][S] = '0;
                            end
                        end
                        else if (MLV == lv)
                        begin : g_mul
                            apj_fxmul u_mul
                            (
                                .clk (clk),
                                .en  (en),
                                .a   (bank[g][lv-1][OPA]),
                                .b   (bank[g][lv-1][OPB]),
                                .p   (bank[g][lv][S])
                            );
                        end
                        else if (MLV < lv)
                        begin : g_dly
                            // finished monomial waits out this level
                            val_t dly_reg [MUL_LAT];

                            always_ff @(posedge clk)
                            begin
                                if (en)
                                begin
                                    dly_reg[0] <= bank[g][lv-1][S];
                                    for (int k = 1; k < MUL_LAT; k++)
                                        dly_reg[k] <= dly_reg[k-1];
                                end
                            end

                            assign bank[g][lv][S] = dly_reg[MUL_LAT-1];
                        end
                        else
                        begin : g_later
                            assign bank[g][lv][S] = '0;
                        end
                    end
                end
            end

            // unused slots of the smaller group
            for (genvar s = CNT; s < TERM_N; s++)
            begin : g_pad
                assign bank[g][lv][s] = '0;
            end
        end
    end

    for (genvar s = 0; s < TERM_N; s++)
    begin : g_out
        assign hip_mono[s] = bank[0][LVL_N][s];
        assign ank_mono[s] = bank[1][LVL_N][s];
    end

endmodule

// File: rtl/apj_coef.sv
// Coefficient multiply: each monomial times its roll, pitch or ankle weight.
module apj_coef import apj_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  val_t hip_mono    [TERM_N],
    input  val_t ank_mono    [TERM_N],
    output val_t roll_term   [TERM_N],
    output val_t pitch_term  [TERM_N],
    output val_t ankle_term  [TERM_N]
);

    for (genvar k = 0; k < TERM_N; k++)
    begin : g_term
        localparam val_t ROLL_C  = coef_fixed(ROLL_N[k]);
        localparam val_t PITCH_C = coef_fixed(PITCH_N[k]);

        apj_fxmul u_roll
        (
            .clk (clk),
            .en  (en),
            .a   (ROLL_C),
            .b   (hip_mono[k]),
            .p   (roll_term[k])
        );

        apj_fxmul u_pitch
        (
            .clk (clk),
            .en  (en),
            .a   (PITCH_C),
            .b   (hip_mono[k]),
            .p   (pitch_term[k])
        );

        if (k < ANKLE_TERM_N)
        begin : g_ank
            localparam val_t ANKLE_C = coef_fixed(ANKLE_N[k]);

            apj_fxmul u_ankle
            (
                .clk (clk),
                .en  (en),
                .a   (ANKLE_C),
                .b   (ank_mono[k]),
                .p   (ankle_term[k])
            );
        end
        else
        begin : g_ank_pad
            assign ankle_term[k] = '0;
        end
    end

endmodule

// File: rtl/apj_sum.sv
// Registered adder tree over the terms (28 -> 7 -> 2 -> 1), then clip to
// the angle range with a saturation flag.
module apj_sum import apj_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  val_t   term [TERM_N],
    output angle_t angle,
    output logic   sat
);

    localparam int S1_N = TERM_N / 4;

    acc_t   s1_reg [S1_N];
    acc_t   s2a_reg;
    acc_t   s2b_reg;
    acc_t   s3_reg;
    angle_t angle_reg;
    logic   sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // groups of four
            for (int k = 0; k < S1_N; k++)
                s1_reg[k] <= acc_t'(term[4*k])   + acc_t'(term[4*k+1])
                           + acc_t'(term[4*k+2]) + acc_t'(term[4*k+3]);

            s2a_reg <= s1_reg[0] + s1_reg[1] + s1_reg[2] + s1_reg[3];
            s2b_reg <= s1_reg[4] + s1_reg[5] + s1_reg[6];

            s3_reg  <= s2a_reg + s2b_reg;

            // clip to the port range
            if (s3_reg > ANGLE_MAX_ACC)
            begin
                angle_reg <= angle_t'(ANGLE_MAX_ACC);
                sat_reg   <= 1'b1;
            end
            else if (s3_reg < ANGLE_MIN_ACC)
            begin
                angle_reg <= angle_t'(ANGLE_MIN_ACC);
                sat_reg   <= 1'b1;
            end
            else
            begin
                angle_reg <= s3_reg[ANGLE_W-1:0];
                sat_reg   <= 1'b0;
            end
        end
    end

    assign angle = angle_reg;
    assign sat   = sat_reg;

endmodule

// File: rtl/actuator_to_joint_polynomial.sv
// Throughput: one request per cycle unless the output stalls; the multiplier
// levels (5 power/cross levels and 1 coefficient level) are fully pipelined.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits; data is not reset.
module actuator_to_joint_polynomial import apj_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    apj_motor_if.sink   motors,
    apj_joint_if.source joints
);

    typedef struct packed {
        angle_t yaw;
        angle_t knee;
    } side_t;

    logic               en;
    logic [LAT-1:0]     vld_reg;
    side_t              side_reg [LAT];
    val_t               hx_reg;
    val_t               hy_reg;
    val_t               ax_reg;
    val_t               ay_reg;
    logic signed [ANGLE_W:0] ksum;
    logic signed [ANGLE_W:0] khalf;
    val_t               hip_mono [TERM_N];
    val_t               ank_mono [TERM_N];
    val_t               roll_term  [TERM_N];
    val_t               pitch_term [TERM_N];
    val_t               ankle_term [TERM_N];
    angle_t             roll_ang;
    angle_t             pitch_ang;
    angle_t             ankle_ang;
    logic               roll_sat;
    logic               pitch_sat;
    logic               ankle_sat;

    // global advance: move unless a finished result is waiting
    assign en           = !vld_reg[LAT-1] || joints.ready;
    assign motors.ready = en;

    // knee: mean of actuators four and five, ties away from zero
    always_comb
    begin
        ksum = {motors.knee_front_motor[ANGLE_W-1], motors.knee_front_motor}
             + {motors.knee_back_motor[ANGLE_W-1], motors.knee_back_motor};
        if (ksum[ANGLE_W])
            khalf = ksum >>> 1;
        else
            khalf = (ksum + (ANGLE_W+1)'(1)) >>> 1;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], motors.valid};
    end

    // entry registers and side-band delay line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx_reg <= val_t'(motors.hip_left_motor);
            hy_reg <= val_t'(motors.hip_right_motor);
            ax_reg <= val_t'(motors.knee_front_motor);
            ay_reg <= val_t'(motors.knee_back_motor);

            side_reg[0].yaw  <= motors.hip_yaw_motor;
            side_reg[0].knee <= khalf[ANGLE_W-1:0];
            for (int k = 1; k < LAT; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    apj_mono u_mono
    (
        .clk      (clk),
        .en       (en),
        .hip_x    (hx_reg),
        .hip_y    (hy_reg),
        .ank_x    (ax_reg),
        .ank_y    (ay_reg),
        .hip_mono (hip_mono),
        .ank_mono (ank_mono)
    );

    apj_coef u_coef
    (
        .clk        (clk),
        .en         (en),
        .hip_mono   (hip_mono),
        .ank_mono   (ank_mono),
        .roll_term  (roll_term),
        .pitch_term (pitch_term),
        .ankle_term (ankle_term)
    );

    apj_sum u_sum_roll
    (
        .clk   (clk),
        .en    (en),
        .term  (roll_term),
        .angle (roll_ang),
        .sat   (roll_sat)
    );

    apj_sum u_sum_pitch
    (
        .clk   (clk),
        .en    (en),
        .term  (pitch_term),
        .angle (pitch_ang),
        .sat   (pitch_sat)
    );

    apj_sum u_sum_ankle
    (
        .clk   (clk),
        .en    (en),
        .term  (ankle_term),
        .angle (ankle_ang),
        .sat   (ankle_sat)
    );

    // result
    assign joints.valid           = vld_reg[LAT-1];
    assign joints.hip_yaw_joint   = side_reg[LAT-1].yaw;
    assign joints.hip_roll_joint  = roll_ang;
    assign joints.hip_pitch_joint = pitch_ang;
    assign joints.knee_joint      = side_reg[LAT-1].knee;
    assign joints.ankle_joint     = ankle_ang;
    assign joints.saturated       = roll_sat | pitch_sat | ankle_sat;

endmodule
